// ----- hdl/sbc_pkg.sv -----
// ----------------------------------------------------------------------------
// sbc_pkg
// Shared constants and types for the swept box contact axis core.
// ----------------------------------------------------------------------------
package sbc_pkg;

   localparam int OFFSET_WIDTH_DEF = 30;
   localparam int WIDTH_BITS       = 28;
   localparam int FACE_BITS        = 3;
   localparam int NUM_AXES         = 3;

   typedef logic signed [FACE_BITS-1:0] face_type;
   typedef logic [1:0]                  axis_type;

   localparam axis_type AXIS_X = 2'd0;
   localparam axis_type AXIS_Y = 2'd1;
   localparam axis_type AXIS_Z = 2'd2;

   localparam face_type FACE_NONE = 3'sd0;

endpackage

// ----- hdl/sbc_if.sv -----
// ----------------------------------------------------------------------------
// sbc_req_if / sbc_rsp_if
// Valid/ready channels carrying box pairs in and contact faces out.
// ----------------------------------------------------------------------------
interface sbc_req_if #(
   parameter int OFFSET_WIDTH = sbc_pkg::OFFSET_WIDTH_DEF
);
   logic                                 valid;
   logic                                 ready;
   logic signed [OFFSET_WIDTH-1:0]       old_offset_x;
   logic signed [OFFSET_WIDTH-1:0]       old_offset_y;
   logic signed [OFFSET_WIDTH-1:0]       old_offset_z;
   logic signed [OFFSET_WIDTH-1:0]       new_offset_x;
   logic signed [OFFSET_WIDTH-1:0]       new_offset_y;
   logic signed [OFFSET_WIDTH-1:0]       new_offset_z;
   logic        [sbc_pkg::WIDTH_BITS-1:0] width_x;
   logic        [sbc_pkg::WIDTH_BITS-1:0] width_y;
   logic        [sbc_pkg::WIDTH_BITS-1:0] width_z;

   modport source (output valid, old_offset_x, old_offset_y, old_offset_z,
                   new_offset_x, new_offset_y, new_offset_z,
                   width_x, width_y, width_z, input ready);
   modport sink   (input valid, old_offset_x, old_offset_y, old_offset_z,
                   new_offset_x, new_offset_y, new_offset_z,
                   width_x, width_y, width_z, output ready);
endinterface

interface sbc_rsp_if;
   logic              valid;
   logic              ready;
   sbc_pkg::face_type contact_face;

   modport source (output valid, contact_face, input ready);
   modport sink   (input valid, contact_face, output ready);
endinterface

// ----- hdl/swept_box_contact_axis_core.sv -----
// ----------------------------------------------------------------------------
// swept_box_contact_axis_core
// Contact face of two moving 3D axis-aligned boxes, five-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one box pair per item: old and new centre offsets (b - a)
//   and summed half-widths per axis. rsp_ch returns one contact_face per item
//   in the same order: 0 for no contact, else +/-(axis+1).
//   An item reaches rsp_ch.valid through five register stages, the accepting
//   edge loading the first. One item can be accepted every cycle unless the
//   pipe is full and stalled. The two multiplier ranks (pairwise slope compare,
//   then the far-edge check against the winner) are each a stage of their own.
//   Each stage holds its item while the next stage is full and stalled, and
//   empty stages fill, so bubbles collapse. When rsp_ch.ready is low the
//   result stays on the port and the pipe keeps taking items until full.
//   Synchronous reset clears all stage valid bits; no result is shown until
//   an item has gone through.
// ----------------------------------------------------------------------------
module swept_box_contact_axis_core #(
   parameter int OFFSET_WIDTH = sbc_pkg::OFFSET_WIDTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   sbc_req_if.sink   req_ch,
   sbc_rsp_if.source rsp_ch
);
   import sbc_pkg::*;

   localparam int MW = (OFFSET_WIDTH > WIDTH_BITS + 1) ? OFFSET_WIDTH : WIDTH_BITS + 1;
   localparam int GW = MW + 2;
   localparam int RW = OFFSET_WIDTH + 2;
   localparam int PW = GW + RW;

   // stage valid bits and enables
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic en1, en2, en3, en4, en5;

   assign en5 = !v5_ff || rsp_ch.ready;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_ch.ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_ch.valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
      end
   end

   // ---------------- stage 1: per-axis prep ----------------
   logic signed [OFFSET_WIDTH-1:0] in_old [NUM_AXES];
   logic signed [OFFSET_WIDTH-1:0] in_new [NUM_AXES];
   logic [WIDTH_BITS-1:0]          in_w   [NUM_AXES];

   assign in_old[0] = req_ch.old_offset_x;
   assign in_old[1] = req_ch.old_offset_y;
   assign in_old[2] = req_ch.old_offset_z;
   assign in_new[0] = req_ch.new_offset_x;
   assign in_new[1] = req_ch.new_offset_y;
   assign in_new[2] = req_ch.new_offset_z;
   assign in_w[0]   = req_ch.width_x;
   assign in_w[1]   = req_ch.width_y;
   assign in_w[2]   = req_ch.width_z;

   logic                 p_sep   [NUM_AXES];
   logic signed [GW-1:0] p_gap   [NUM_AXES];
   logic signed [RW-1:0] p_rate  [NUM_AXES];
   face_type             p_face  [NUM_AXES];
   logic signed [GW-1:0] p_depth [NUM_AXES];
   face_type             p_dface [NUM_AXES];

   logic                  s1_sep_ff;
   logic signed [GW-1:0]  s1_gap_ff   [NUM_AXES];
   logic signed [RW-1:0]  s1_rate_ff  [NUM_AXES];
   face_type              s1_face_ff  [NUM_AXES];
   logic signed [GW-1:0]  s1_depth_ff [NUM_AXES];
   face_type              s1_dface_ff [NUM_AXES];
   logic [WIDTH_BITS-1:0] s1_w_ff     [NUM_AXES];

   for (genvar i = 0; i < NUM_AXES; i++) begin : g_prep
      sbc_prep #(.OW(OFFSET_WIDTH), .GW(GW), .RW(RW), .AXIS(i)) u_prep (
         .old_offset (in_old[i]),
         .new_offset (in_new[i]),
         .width      (in_w[i]),
         .sep        (p_sep[i]),
         .gap        (p_gap[i]),
         .rate       (p_rate[i]),
         .face       (p_face[i]),
         .depth      (p_depth[i]),
         .depth_face (p_dface[i])
      );

      always_ff @(posedge clock) begin
         if (en1) begin
            s1_gap_ff[i]   <= p_gap[i];
            s1_rate_ff[i]  <= p_rate[i];
            s1_face_ff[i]  <= p_face[i];
            s1_depth_ff[i] <= p_depth[i];
            s1_dface_ff[i] <= p_dface[i];
            s1_w_ff[i]     <= in_w[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_sep_ff <= p_sep[0] || p_sep[1] || p_sep[2];
      end
   end

   // ---------------- stage 2: pairwise slope products ----------------
   // pair 0: (x,y), pair 1: (x,z), pair 2: (y,z)
   logic signed [PW-1:0] s2_pa [NUM_AXES];
   logic signed [PW-1:0] s2_pb [NUM_AXES];

   for (genvar k = 0; k < NUM_AXES; k++) begin : g_pair
      localparam int P = (k == 2) ? 1 : 0;
      localparam int Q = (k == 0) ? 1 : 2;
      sbc_mul #(.AW(GW), .BW(RW)) u_mul_a (
         .clock (clock), .en (en2),
         .a (s1_gap_ff[P]), .b (s1_rate_ff[Q]), .prod (s2_pa[k])
      );
      sbc_mul #(.AW(GW), .BW(RW)) u_mul_b (
         .clock (clock), .en (en2),
         .a (s1_gap_ff[Q]), .b (s1_rate_ff[P]), .prod (s2_pb[k])
      );
   end

   logic                  s2_sep_ff;
   face_type              s2_ovl_face_ff;
   logic signed [GW-1:0]  s2_gap_ff  [NUM_AXES];
   logic signed [RW-1:0]  s2_rate_ff [NUM_AXES];
   face_type              s2_face_ff [NUM_AXES];
   logic [WIDTH_BITS-1:0] s2_w_ff    [NUM_AXES];

   face_type             ovl_face;
   logic signed [GW-1:0] ovl_depth;

   // shallowest penetration, lower axis on ties
   always_comb begin
      ovl_face  = s1_dface_ff[0];
      ovl_depth = s1_depth_ff[0];
      if (s1_depth_ff[1] < ovl_depth) begin
         ovl_face  = s1_dface_ff[1];
         ovl_depth = s1_depth_ff[1];
      end
      if (s1_depth_ff[2] < ovl_depth) begin
         ovl_face = s1_dface_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_sep_ff      <= s1_sep_ff;
         s2_ovl_face_ff <= ovl_face;
         s2_gap_ff      <= s1_gap_ff;
         s2_rate_ff     <= s1_rate_ff;
         s2_face_ff     <= s1_face_ff;
         s2_w_ff        <= s1_w_ff;
      end
   end

   // ---------------- stage 3: pick best axis ----------------
   axis_type win [NUM_AXES];

   for (genvar k = 0; k < NUM_AXES; k++) begin : g_win
      localparam axis_type P = (k == 2) ? AXIS_Y : AXIS_X;
      localparam axis_type Q = (k == 0) ? AXIS_Y : AXIS_Z;
      logic signed [PW:0] cr;
      assign cr = (PW+1)'(s2_pa[k]) - (PW+1)'(s2_pb[k]);
      always_comb begin
         if (cr > 0) begin
            win[k] = P;
         end else if (cr < 0) begin
            win[k] = Q;
         end else begin
            win[k] = (s2_w_ff[P] > s2_w_ff[Q]) ? Q : P;
         end
      end
   end

   axis_type             best;
   logic signed [GW-1:0] gap_b;

   assign best  = (win[0] == AXIS_X) ? win[1] : win[2];
   assign gap_b = s2_gap_ff[best];

   logic                  s3_sep_ff;
   logic                  s3_ovl_ff;
   face_type              s3_ovl_face_ff;
   face_type              s3_face_b_ff;
   logic signed [GW-1:0]  s3_gap_b_ff;
   logic signed [RW-1:0]  s3_rate_b_ff;
   logic signed [GW-1:0]  s3_far_ff  [NUM_AXES];
   logic signed [RW-1:0]  s3_rate_ff [NUM_AXES];

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_sep_ff      <= s2_sep_ff;
         s3_ovl_ff      <= gap_b < 0;
         s3_ovl_face_ff <= s2_ovl_face_ff;
         s3_face_b_ff   <= s2_face_ff[best];
         s3_gap_b_ff    <= gap_b;
         s3_rate_b_ff   <= s2_rate_ff[best];
         s3_rate_ff     <= s2_rate_ff;
         for (int i = 0; i < NUM_AXES; i++) begin
            s3_far_ff[i] <= s2_gap_ff[i] + $signed(GW'({1'b0, s2_w_ff[i], 1'b0}));
         end
      end
   end

   // ---------------- stage 4: far-edge products ----------------
   logic signed [PW-1:0] s4_pn [NUM_AXES];
   logic signed [PW-1:0] s4_pf [NUM_AXES];

   for (genvar i = 0; i < NUM_AXES; i++) begin : g_far
      sbc_mul #(.AW(GW), .BW(RW)) u_mul_n (
         .clock (clock), .en (en4),
         .a (s3_gap_b_ff), .b (s3_rate_ff[i]), .prod (s4_pn[i])
      );
      sbc_mul #(.AW(GW), .BW(RW)) u_mul_f (
         .clock (clock), .en (en4),
         .a (s3_far_ff[i]), .b (s3_rate_b_ff), .prod (s4_pf[i])
      );
   end

   logic     s4_sep_ff;
   logic     s4_ovl_ff;
   face_type s4_ovl_face_ff;
   face_type s4_face_b_ff;

   always_ff @(posedge clock) begin
      if (en4) begin
         s4_sep_ff      <= s3_sep_ff;
         s4_ovl_ff      <= s3_ovl_ff;
         s4_ovl_face_ff <= s3_ovl_face_ff;
         s4_face_b_ff   <= s3_face_b_ff;
      end
   end

   // ---------------- stage 5: dodge check, output register ----------------
   logic     dodge;
   face_type face_in;
   face_type face_ff;

   always_comb begin
      dodge = 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
         if ((PW+1)'(s4_pn[i]) - (PW+1)'(s4_pf[i]) >= 0) begin
            dodge = 1'b1;
         end
      end
      if (s4_sep_ff) begin
         face_in = FACE_NONE;
      end else if (s4_ovl_ff) begin
         face_in = s4_ovl_face_ff;
      end else if (dodge) begin
         face_in = FACE_NONE;
      end else begin
         face_in = s4_face_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         face_ff <= face_in;
      end
   end

   assign rsp_ch.valid        = v5_ff;
   assign rsp_ch.contact_face = face_ff;

endmodule

// ----- hdl/sbc_prep.sv -----
// ----------------------------------------------------------------------------
// sbc_prep
// Per-axis front end: separation test, direction, gap, rate, overlap depth.
// ----------------------------------------------------------------------------
module sbc_prep #(
   parameter int OW   = sbc_pkg::OFFSET_WIDTH_DEF,
   parameter int GW   = 32,
   parameter int RW   = 32,
   parameter int AXIS = 0
) (
   input  logic signed [OW-1:0]                old_offset,
   input  logic signed [OW-1:0]                new_offset,
   input  logic        [sbc_pkg::WIDTH_BITS-1:0] width,
   output logic                                sep,
   output logic signed [GW-1:0]                gap,
   output logic signed [RW-1:0]                rate,
   output sbc_pkg::face_type                   face,
   output logic signed [GW-1:0]                depth,
   output sbc_pkg::face_type                   depth_face
);
   import sbc_pkg::*;

   localparam face_type FPOS = face_type'(AXIS + 1);

   logic signed [GW-1:0] ox;
   logic signed [GW-1:0] nx;
   logic signed [GW-1:0] wx;
   logic signed [GW-1:0] dd;
   logic signed [RW-1:0] rr;
   logic                 neg;

   always_comb begin
      ox  = GW'(old_offset);
      nx  = GW'(new_offset);
      wx  = $signed(GW'({1'b0, width}));
      if (ox > 0) begin
         sep = (ox >= wx) && (nx >= wx);
      end else begin
         sep = (ox <= -wx) && (nx <= -wx);
      end
      rr   = RW'(old_offset) - RW'(new_offset);
      neg  = rr < 0;
      face = neg ? FPOS : -FPOS;
      dd   = neg ? -ox : ox;
      gap  = dd - wx;
      rate = neg ? -rr : rr;
      // already-overlapping depth and the face it would report
      if (dd >= 0) begin
         depth      = wx - dd;
         depth_face = face;
      end else begin
         depth      = wx + dd;
         depth_face = (rr != 0) ? FACE_NONE : -face;
      end
   end

endmodule

// ----- hdl/sbc_mul.sv -----
// ----------------------------------------------------------------------------
// sbc_mul
// Registered signed multiplier lane with load enable.
// ----------------------------------------------------------------------------
module sbc_mul #(
   parameter int AW = 32,
   parameter int BW = 32
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [AW-1:0]    a,
   input  logic signed [BW-1:0]    b,
   output logic signed [AW+BW-1:0] prod
);
   logic signed [AW+BW-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= a * b;
      end
   end

   assign prod = prod_ff;

endmodule

// ----- hdl/sbc_checker.sv -----
// ----------------------------------------------------------------------------
// sbc_checker
// Port-level checks on the contact core, bound to the top level.
// ----------------------------------------------------------------------------
module sbc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input sbc_pkg::face_type rsp_face
);
   import sbc_pkg::*;

   // a draining output means the whole pipe can move
   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("req not ready while rsp is draining");

   a_face_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_face != 3'sb100))
      else $error("contact face out of range");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_face)))
      else $error("stalled item changed");

endmodule

bind swept_box_contact_axis_core sbc_checker u_sbc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_face  (rsp_ch.contact_face)
);

// ----- tb/sbc_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// sbc_tb_pkg
// Shared item type for the contact face testbench.
// ----------------------------------------------------------------------------
package sbc_tb_pkg;

   typedef struct packed {
      logic signed [29:0] old_x;
      logic signed [29:0] old_y;
      logic signed [29:0] old_z;
      logic signed [29:0] new_x;
      logic signed [29:0] new_y;
      logic signed [29:0] new_z;
      logic [27:0]        wid_x;
      logic [27:0]        wid_y;
      logic [27:0]        wid_z;
   } box_pair_t;

endpackage

// ----- tb/sbc_contact_checker.sv -----
// ----------------------------------------------------------------------------
// sbc_contact_checker
// Watches both channels, predicts the contact face of every accepted box
// pair and compares it with the returned face in order.
// ----------------------------------------------------------------------------
module sbc_contact_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_fire,
   input  logic signed [29:0] old_x, old_y, old_z,
   input  logic signed [29:0] new_x, new_y, new_z,
   input  logic [27:0] wid_x, wid_y, wid_z,
   input  logic rsp_fire,
   input  sbc_pkg::face_type contact_face,
   output int   fail_count,
   output int   faces_pending
);
   import sbc_pkg::*;

   face_type face_queue[$];

   assign faces_pending = face_queue.size();

   function automatic logic signed [63:0] sext30(input logic signed [29:0] v);
      sext30 = v;
   endfunction

   function automatic int pick(input logic signed [63:0] gap[3],
                               input logic signed [63:0] rate[3],
                               input logic signed [63:0] wd[3], input int p, input int q);
      logic signed [127:0] c;
      c = 128'(gap[p]) * 128'(rate[q]) - 128'(gap[q]) * 128'(rate[p]);
      if (c > 0) return p;
      if (c < 0) return q;
      return (wd[p] > wd[q]) ? q : p;
   endfunction

   function automatic face_type predict_face(input logic signed [63:0] oo[3],
                                             input logic signed [63:0] no[3],
                                             input logic signed [63:0] wd[3]);
      logic signed [63:0] gap[3], rate[3], fc[3];
      logic signed [63:0] depth, ret, d, nd, nr, far_edge;
      logic signed [127:0] c;
      int best;
      for (int i = 0; i < 3; i++) begin
         if (oo[i] > 0) begin
            if (oo[i] >= wd[i] && no[i] >= wd[i]) return FACE_NONE;
         end else begin
            if (oo[i] <= -wd[i] && no[i] <= -wd[i]) return FACE_NONE;
         end
         gap[i] = oo[i];
         rate[i] = oo[i] - no[i];
      end
      for (int i = 0; i < 3; i++) begin
         if (rate[i] >= 0) begin
            fc[i] = -(i + 1);
         end else begin
            fc[i] = i + 1;
            gap[i] = -gap[i];
            rate[i] = -rate[i];
         end
         gap[i] -= wd[i];
      end
      best = pick(gap, rate, wd, 0, 1);
      best = pick(gap, rate, wd, best, 2);
      if (gap[best] < 0) begin
         // already overlapping: shallowest penetration wins
         depth = 64'sd2147483647;
         ret = 0;
         for (int i = 0; i < 3; i++) begin
            d = gap[i] + wd[i];
            if (d >= 0) begin
               nd = wd[i] - d;
               nr = fc[i];
            end else begin
               nd = wd[i] + d;
               nr = (rate[i] != 0) ? 0 : -fc[i];
            end
            if (nd < depth) begin
               depth = nd;
               ret = nr;
            end
         end
         return face_type'(ret[2:0]);
      end
      for (int i = 0; i < 3; i++) begin
         far_edge = gap[i] + 2 * wd[i];
         c = 128'(gap[best]) * 128'(rate[i]) - 128'(far_edge) * 128'(rate[best]);
         if (c >= 0) return FACE_NONE;
      end
      return face_type'(fc[best][2:0]);
   endfunction

   always @(posedge clock) begin
      logic signed [63:0] oo[3], no[3], wd[3];
      face_type want;
      if (!reset) begin
         if (req_fire) begin
            oo[0] = sext30(old_x); oo[1] = sext30(old_y); oo[2] = sext30(old_z);
            no[0] = sext30(new_x); no[1] = sext30(new_y); no[2] = sext30(new_z);
            wd[0] = {36'd0, wid_x}; wd[1] = {36'd0, wid_y}; wd[2] = {36'd0, wid_z};
            face_queue.push_back(predict_face(oo, no, wd));
         end
         if (rsp_fire) begin
            if (face_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected contact face %0d", contact_face);
            end else begin
               want = face_queue.pop_front();
               if (want !== contact_face) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("contact_face mismatch: expected %0d actual %0d",
                              want, contact_face);
               end
            end
         end
      end
   end

   initial fail_count = 0;

endmodule

// ----- tb/tb_swept_box_contact_axis_core.sv -----
// ----------------------------------------------------------------------------
// tb_swept_box_contact_axis_core
// Drives directed and random box pairs with random gaps and stalls; the
// checker predicts each contact face and counts mismatches.
// ----------------------------------------------------------------------------
module tb_swept_box_contact_axis_core;
   import sbc_pkg::*;
   import sbc_tb_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;

   logic clock = 0;
   logic reset = 1;
   int   fail_count, faces_pending;
   int   idle_cycles = 0;
   int   idle_pct = 20;
   logic send_done = 0;

   sbc_req_if #(.OFFSET_WIDTH(30)) req_ch ();
   sbc_rsp_if rsp_ch ();

   swept_box_contact_axis_core #(.OFFSET_WIDTH(30)) dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source)
   );

   sbc_contact_checker checker_i (
      .clock(clock), .reset(reset),
      .req_fire(req_ch.valid && req_ch.ready),
      .old_x(req_ch.old_offset_x), .old_y(req_ch.old_offset_y),
      .old_z(req_ch.old_offset_z), .new_x(req_ch.new_offset_x),
      .new_y(req_ch.new_offset_y), .new_z(req_ch.new_offset_z),
      .wid_x(req_ch.width_x), .wid_y(req_ch.width_y), .wid_z(req_ch.width_z),
      .rsp_fire(rsp_ch.valid && rsp_ch.ready), .contact_face(rsp_ch.contact_face),
      .fail_count(fail_count), .faces_pending(faces_pending)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      req_ch.valid = 0;
      {req_ch.old_offset_x, req_ch.old_offset_y, req_ch.old_offset_z,
       req_ch.new_offset_x, req_ch.new_offset_y, req_ch.new_offset_z,
       req_ch.width_x, req_ch.width_y, req_ch.width_z} = '0;
      rsp_ch.ready = 0;
   end

   // receiver stalls at random
   always @(negedge clock)
      rsp_ch.ready <= reset ? 1'b0 : ($urandom_range(99) >= idle_pct);

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || reset)
         idle_cycles <= 0;
      else if (send_done && faces_pending == 0)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic send_pair(input box_pair_t p);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 0;
         @(negedge clock);
      end
      req_ch.valid <= 1;
      req_ch.old_offset_x <= p.old_x; req_ch.old_offset_y <= p.old_y;
      req_ch.old_offset_z <= p.old_z; req_ch.new_offset_x <= p.new_x;
      req_ch.new_offset_y <= p.new_y; req_ch.new_offset_z <= p.new_z;
      req_ch.width_x <= p.wid_x; req_ch.width_y <= p.wid_y; req_ch.width_z <= p.wid_z;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [27:0] rand_width();
      case ($urandom_range(3))
         0: return 28'($urandom_range(15));
         1: return 28'($urandom_range(1000));
         2: return 28'(28'hFFFFFFF - 28'($urandom_range(3)));
         default: return 28'($urandom);
      endcase
   endfunction

   function automatic logic signed [29:0] rand_offset(input logic [27:0] w);
      int signed r;
      case ($urandom_range(4))
         0: r = $urandom_range(2 * w + 4) - w - 2;
         1: r = (w + $urandom_range(3) - 1);
         2: r = -(w + $urandom_range(3) - 1);
         3: r = $urandom;
         default: r = $urandom_range(8) - 4;
      endcase
      return 30'(r);
   endfunction

   function automatic box_pair_t rand_pair();
      box_pair_t p;
      p.wid_x = rand_width(); p.wid_y = rand_width(); p.wid_z = rand_width();
      // mostly nearby boxes so every branch is reached
      p.old_x = rand_offset(p.wid_x); p.old_y = rand_offset(p.wid_y);
      p.old_z = rand_offset(p.wid_z);
      p.new_x = ($urandom_range(3) == 0) ? p.old_x : rand_offset(p.wid_x);
      p.new_y = ($urandom_range(3) == 0) ? p.old_y : rand_offset(p.wid_y);
      p.new_z = ($urandom_range(3) == 0) ? p.old_z : rand_offset(p.wid_z);
      return p;
   endfunction

   function automatic box_pair_t mk(input int ox, oy, oz, nx, ny, nz, wx, wy, wz);
      box_pair_t p;
      p.old_x = 30'(ox); p.old_y = 30'(oy); p.old_z = 30'(oz);
      p.new_x = 30'(nx); p.new_y = 30'(ny); p.new_z = 30'(nz);
      p.wid_x = 28'(wx); p.wid_y = 28'(wy); p.wid_z = 28'(wz);
      return p;
   endfunction

   initial begin
      box_pair_t p;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(negedge clock);
      // directed: separation, overlap, still axes, ties, extremes
      send_pair(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_pair(mk(20, 0, 0, 20, 0, 0, 10, 10, 10));
      send_pair(mk(-20, 0, 0, -20, 0, 0, 10, 10, 10));
      send_pair(mk(3, 1, 2, 3, 1, 2, 10, 10, 10));
      send_pair(mk(-3, 5, -8, -2, 4, -9, 10, 10, 10));
      send_pair(mk(20, 20, 0, 5, 5, 0, 10, 10, 10));
      send_pair(mk(20, 30, 0, 5, 15, 0, 10, 20, 10));
      send_pair(mk(20, 20, 20, 0, 0, 0, 10, 10, 10));
      send_pair(mk(-20, 0, 0, -5, 0, 0, 10, 10, 10));
      send_pair(mk(20, 0, 0, -30, 0, 0, 10, 10, 10));
      send_pair(mk(20, 15, 0, 5, 15, 0, 10, 10, 10));
      send_pair(mk(-9, 0, 0, 9, 0, 0, 10, 10, 10));
      send_pair(mk(12, 4, 1, 8, 4, 1, 10, 10, 10));
      send_pair(mk(-536870912, 536870911, -536870912, 536870911, -536870912,
                   536870911, 268435455, 268435455, 268435455));
      send_pair(mk(536870911, 536870911, 536870911, -536870912, -536870912,
                   -536870912, 268435455, 0, 268435455));
      send_pair(mk(-1, -1, -1, -1, -1, -1, 0, 0, 0));
      send_pair(mk(300000000, 0, 0, -300000000, 0, 0, 268435455, 268435455, 268435455));
      // random, with a long no-idle stretch and a full drain pause
      for (int n = 0; n < 500; n++) begin
         idle_pct = (n >= 150 && n < 250) ? 0 : 20;
         if (n == 300) begin
            req_ch.valid <= 0;
            while (faces_pending != 0) @(negedge clock);
         end
         p = rand_pair();
         if ($urandom_range(9) == 0)
            p = box_pair_t'($bits(box_pair_t)'({$urandom, $urandom, $urandom,
                                                $urandom, $urandom, $urandom,
                                                $urandom, $urandom, $urandom}));
         send_pair(p);
      end
      req_ch.valid <= 0;
      send_done = 1;
      while (faces_pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ----- swept_box_contact_axis_core.f -----
hdl/sbc_pkg.sv
hdl/sbc_if.sv
hdl/sbc_prep.sv
hdl/sbc_mul.sv
hdl/swept_box_contact_axis_core.sv
hdl/sbc_checker.sv
tb/sbc_tb_pkg.sv
tb/sbc_contact_checker.sv
tb/tb_swept_box_contact_axis_core.sv
